### rtl/mufd_pkg.sv
package mufd_pkg;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] peer_address;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_t;

endpackage

### rtl/mufd_byte_if.sv
interface mufd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/mufd_res_if.sv
interface mufd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] peer_address;
  logic [7:0]  payload_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output peer_address, output payload_length,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input peer_address, input payload_length,
                  input payload_byte, input last, output ready);
endinterface

### rtl/mufd_in_reg.sv
module mufd_in_reg
  import mufd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  [7:0] in_byte_i,
  output logic  in_ready_o,
  output byte_t byte_o,
  input  logic  take_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_o.valid   = valid_q;
  assign byte_o.rx_byte = byte_q;

endmodule

### rtl/mufd_parser.sv
module mufd_parser
  import mufd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  byte_t byte_i,
  input  logic  take_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_O       = 4'd1;
  localparam logic [3:0] PH_OK      = 4'd2;
  localparam logic [3:0] PH_OKCR    = 4'd3;
  localparam logic [3:0] PH_F1      = 4'd4;
  localparam logic [3:0] PH_LEN     = 4'd5;
  localparam logic [3:0] PH_ADDR_HI = 4'd6;
  localparam logic [3:0] PH_ADDR_LO = 4'd7;
  localparam logic [3:0] PH_SKIP1   = 4'd8;
  localparam logic [3:0] PH_SKIP2   = 4'd9;
  localparam logic [3:0] PH_DATA    = 4'd10;

  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] HDR0    = 8'hF1;
  localparam logic [7:0] HDR1    = 8'hDD;
  localparam logic [7:0] MIN_LEN = 8'd4;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [15:0] address_q, address_d;
  logic [7:0]  length_q, length_d;
  logic [3:0]  restart;
  logic [7:0]  left_dec;
  logic [7:0]  b;
  logic        step;

  assign b    = byte_i.rx_byte;
  assign step = byte_i.valid && take_i;

  always_comb begin
    if (b == CH_O) begin
      restart = PH_O;
    end else if (b == HDR0) begin
      restart = PH_F1;
    end else begin
      restart = PH_HUNT;
    end
  end

  assign left_dec = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    address_d    = address_q;
    length_d     = length_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KIND_ACK, peer_address: 16'd0, payload_length: 8'd0,
                     payload_byte: 8'd0, last: 1'b1};
    case (phase_q)
      PH_O: begin
        phase_d = (b == CH_K) ? PH_OK : restart;
      end
      PH_OK: begin
        phase_d = (b == CH_CR) ? PH_OKCR : restart;
      end
      PH_OKCR: begin
        if (b == CH_LF) begin
          phase_d     = PH_HUNT;
          res_valid_o = 1'b1;
        end else begin
          phase_d = restart;
        end
      end
      PH_F1: begin
        phase_d = (b == HDR1) ? PH_LEN : restart;
      end
      PH_LEN: begin
        if (b < MIN_LEN) begin
          phase_d      = PH_HUNT;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_ERROR;
        end else begin
          length_d     = b - MIN_LEN;
          bytes_left_d = b - MIN_LEN;
          phase_d      = PH_ADDR_HI;
        end
      end
      PH_ADDR_HI: begin
        address_d = {b, 8'd0};
        phase_d   = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        address_d = {address_q[15:8], b};
        phase_d   = PH_SKIP1;
      end
      PH_SKIP1: begin
        phase_d = PH_SKIP2;
      end
      PH_SKIP2: begin
        if (length_q == 8'd0) begin
          phase_d            = PH_HUNT;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_EMPTY;
          res_o.peer_address = address_q;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_left_d         = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_HUNT;
        end
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_DATA;
        res_o.peer_address   = address_q;
        res_o.payload_length = length_q;
        res_o.payload_byte   = b;
        res_o.last           = (left_dec == 8'd0);
      end
      default: begin
        phase_d = restart;
      end
    endcase
    if (!step) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      bytes_left_q <= 8'd0;
      address_q    <= 16'd0;
      length_q     <= 8'd0;
    end else if (step) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      address_q    <= address_d;
      length_q     <= length_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_DATA)
    else $error("parser phase out of range");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> length_q != 8'd0 && bytes_left_q != 8'd0)
    else $error("payload phase with nothing left");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= length_q)
    else $error("bytes left exceeds frame length");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(bytes_left_q))
    else $error("parser state moved without a byte");
`endif

endmodule

### rtl/mufd_out_reg.sv
module mufd_out_reg
  import mufd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic take_o,
  output logic out_valid_o,
  output res_t out_o,
  input  logic out_ready_i
);

  logic valid_q, valid_d;
  res_t res_q;

  assign take_o  = !valid_q || out_ready_i;
  assign valid_d = take_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

`ifndef NO_ASSERTIONS
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(res_q))
    else $error("result changed while stalled");
`endif

endmodule

### rtl/mesh_uart_frame_deframer.sv
// Mesh UART frame deframer.
// rx_i carries one received serial byte per transaction. res_o carries at most
// one result per byte: an ack (OK CR LF), a payload byte tagged with peer
// address and payload length, an empty-frame notice or a bad-length error.
// last is set on acks, errors, empty frames and the final payload byte.
// Frame: F1 DD, length L, address high, address low, two skipped bytes,
// then L-4 payload bytes streamed as they arrive.
// A byte accepted at rx_i passes the input register and then the result
// register on its way to res_o.
// Throughput: one byte per cycle while the receiver does not stall; the parser
// state machine advances once per byte taken.
// Reset clears the parser to hunting and empties both registers.
// When the receiver stalls, the held result stays on res_o, the parser stops
// and rx_i.ready falls once the input register is full.
module mesh_uart_frame_deframer
  import mufd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mufd_byte_if.sink   rx_i,
  mufd_res_if.source  res_o
);

  byte_t byte_s;
  logic  take;
  logic  res_valid;
  res_t  res_s;
  res_t  out_s;

  mufd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .byte_o     (byte_s),
    .take_i     (take)
  );

  mufd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_s),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res_s)
  );

  mufd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_s),
    .take_o      (take),
    .out_valid_o (res_o.valid),
    .out_o       (out_s),
    .out_ready_i (res_o.ready)
  );

  assign res_o.kind           = out_s.kind;
  assign res_o.peer_address   = out_s.peer_address;
  assign res_o.payload_length = out_s.payload_length;
  assign res_o.payload_byte   = out_s.payload_byte;
  assign res_o.last           = out_s.last;

endmodule
